>>> hw/rtl/srse_pkg.sv
// Shared types, codes and constants for the shared ring slot engine.
package srse_pkg;

  // Field widths fixed by the slot descriptor format
  localparam int OP_W    = 3;
  localparam int LEN_W   = 16;
  localparam int SLOT_W  = 5;
  localparam int COUNT_W = 6;
  localparam int KIND_W  = 4;
  localparam int CFG_IDX_W = 1;

  // Default ring depth
  localparam int RING_SLOTS_DEF = 32;

  // Register reset values
  localparam logic [LEN_W-1:0]   MAX_FRAME_LEN_RST = 16'd1518;
  localparam logic [COUNT_W-1:0] BURST_LIMIT_RST   = 6'd32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_LIMIT   = 1'd1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SEND  = 3'd0;
  localparam logic [OP_W-1:0] OP_POLL  = 3'd1;
  localparam logic [OP_W-1:0] OP_FILL  = 3'd2;
  localparam logic [OP_W-1:0] OP_FREE  = 3'd3;
  localparam logic [OP_W-1:0] OP_RESET = 3'd4;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_SENT         = 4'd0;
  localparam logic [KIND_W-1:0] KIND_DROP_INVALID = 4'd1;
  localparam logic [KIND_W-1:0] KIND_DROP_LONG    = 4'd2;
  localparam logic [KIND_W-1:0] KIND_DROP_FULL    = 4'd3;
  localparam logic [KIND_W-1:0] KIND_DELIVERED    = 4'd4;
  localparam logic [KIND_W-1:0] KIND_RX_OVERSIZE  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_POLL_DONE    = 4'd6;
  localparam logic [KIND_W-1:0] KIND_GUEST_ACK    = 4'd7;
  localparam logic [KIND_W-1:0] KIND_RESET_DONE   = 4'd8;

  // Input word
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [LEN_W-1:0]   frame_length;
    logic [SLOT_W-1:0]  slot_index;
    logic [COUNT_W-1:0] buffers_available;
  } item_t;

  // Result word
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SLOT_W-1:0]  slot_used;
    logic [LEN_W-1:0]   length_out;
    logic [COUNT_W-1:0] delivered_count;
    logic               last;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch_item;
    logic exec_single;
    logic poll_reset;
    logic poll_idle;
    logic walk_init;
    logic walk_step;
    logic walk_stop;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            reset_pending;
    logic            link_valid;
    logic            out_free;
    logic            walk_visit;
  } dp_status_t;

endpackage

>>> hw/rtl/shared_ring_slot_engine.sv
// Send/guest ops: result registered once the output is free; next word taken back in idle.
// Receive poll: one slot a cycle through the status flags while the result register is free.
// The walk is bounded by burst limit and ring depth; each visit waits on the result register.
// A held result does not block the next input word from being accepted.
// Reset (rst, synchronous): all slots free, positions zero, link invalid, no reset pending,
// registers at defaults. No clearing pass; slot lengths are undefined until filled.
module shared_ring_slot_engine #(
  parameter int RING_SLOTS = srse_pkg::RING_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  srse_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output srse_pkg::result_t              result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [srse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srse_pkg::LEN_W-1:0]     cfg_data
);
  import srse_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  srse_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  srse_dp #(
    .RING_SLOTS (RING_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

>>> hw/rtl/srse_ctrl.sv
// Sequencer for the shared ring slot engine: decode, poll walk and hand-off.
module srse_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  srse_pkg::dp_status_t status,
  output srse_pkg::dp_cmd_t    cmd
);
  import srse_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_OP   = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign item_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.latch_item = item_valid && item_ready;
    unique case (state)
      S_IDLE: begin
        if (item_valid) state_next = S_OP;
      end
      S_OP: begin
        if (status.out_free) begin
          state_next = S_IDLE;
          unique case (status.op)
            OP_SEND, OP_FILL, OP_FREE, OP_RESET: cmd.exec_single = 1'b1;
            OP_POLL: begin
              priority if (status.reset_pending) begin
                cmd.poll_reset = 1'b1;
              end else if (!status.link_valid) begin
                cmd.poll_idle = 1'b1;
              end else begin
                cmd.walk_init = 1'b1;
                state_next    = S_WALK;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_WALK: begin
        if (status.out_free) begin
          if (status.walk_visit) begin
            cmd.walk_step = 1'b1;
          end else begin
            cmd.walk_stop = 1'b1;
            state_next    = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

>>> hw/rtl/srse_dp.sv
// Ring state, configuration registers, poll walker and result register.
module srse_dp #(
  parameter int RING_SLOTS = srse_pkg::RING_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  srse_pkg::item_t                     item,
  input  logic                                cfg_valid,
  input  logic [srse_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srse_pkg::LEN_W-1:0]          cfg_data,
  input  srse_pkg::dp_cmd_t                   cmd,
  output srse_pkg::dp_status_t                status,
  output logic                                result_valid,
  input  logic                                result_ready,
  output srse_pkg::result_t                   result
);
  import srse_pkg::*;

  localparam int IDX_W  = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int WALK_W = $clog2(RING_SLOTS + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(RING_SLOTS - 1);
  localparam logic [WALK_W-1:0] WALK_LIMIT = WALK_W'(RING_SLOTS);

  // Configuration
  logic [LEN_W-1:0]   max_frame_len;
  logic [COUNT_W-1:0] burst_limit;

  // Latched input word
  item_t cur;

  // Ring state: one up and one down filled flag per slot, lengths in a register file
  logic [RING_SLOTS-1:0] up_filled;
  logic [RING_SLOTS-1:0] down_filled;
  logic [LEN_W-1:0]      len_mem [RING_SLOTS];
  logic [IDX_W-1:0]      up_pos;
  logic [IDX_W-1:0]      down_pos;
  logic                  link_valid;
  logic                  reset_pending;

  // Walker
  logic [IDX_W-1:0]   wpos;
  logic [IDX_W-1:0]   wpos_inc;
  logic [WALK_W-1:0]  walked;
  logic [COUNT_W-1:0] cnt;

  logic               out_free;
  logic               emit;
  result_t            res_next;
  logic [IDX_W-1:0]   cur_idx;
  logic               cur_in_range;
  logic [LEN_W-1:0]   wlen;
  logic               wlen_over;
  logic               walk_more;
  logic               walk_visit;
  logic [KIND_W-1:0]  send_kind;
  logic               send_ok;

  assign out_free     = !result_valid || result_ready;
  assign cur_idx      = cur.slot_index[IDX_W-1:0];
  assign cur_in_range = ({1'b0, cur.slot_index} < (SLOT_W + 1)'(RING_SLOTS));
  assign wpos_inc     = (wpos == LAST_IDX) ? '0 : wpos + IDX_W'(1);
  assign wlen_over    = wlen > max_frame_len;
  assign walk_more    = (cnt < burst_limit) && (walked < WALK_LIMIT) && down_filled[wpos];
  assign walk_visit   = walk_more && (wlen_over || (cnt < cur.buffers_available));

  assign status.op            = cur.op;
  assign status.reset_pending = reset_pending;
  assign status.link_valid    = link_valid;
  assign status.out_free      = out_free;
  assign status.walk_visit    = walk_visit;

  // Host send checks, in priority order
  always_comb begin
    send_ok = 1'b0;
    priority if (!link_valid) begin
      send_kind = KIND_DROP_INVALID;
    end else if (cur.frame_length > max_frame_len) begin
      send_kind = KIND_DROP_LONG;
    end else if (up_filled[up_pos]) begin
      send_kind = KIND_DROP_FULL;
    end else begin
      send_kind = KIND_SENT;
      send_ok   = 1'b1;
    end
  end

  // Result word for this cycle
  always_comb begin
    emit     = 1'b0;
    res_next = '0;
    res_next.last = 1'b1;
    if (cmd.exec_single) begin
      emit = 1'b1;
      if (cur.op == OP_SEND) begin
        res_next.kind       = send_kind;
        res_next.slot_used  = SLOT_W'(up_pos);
        res_next.length_out = cur.frame_length;
      end else begin
        res_next.kind       = KIND_GUEST_ACK;
        res_next.slot_used  = cur.slot_index;
        res_next.length_out = (cur.op == OP_FILL) ? cur.frame_length : '0;
      end
    end else if (cmd.poll_reset) begin
      emit          = 1'b1;
      res_next.kind = KIND_RESET_DONE;
    end else if (cmd.poll_idle) begin
      emit          = 1'b1;
      res_next.kind = KIND_POLL_DONE;
    end else if (cmd.walk_step) begin
      emit                = 1'b1;
      res_next.last       = 1'b0;
      res_next.slot_used  = SLOT_W'(wpos);
      res_next.length_out = wlen;
      if (wlen_over) begin
        res_next.kind            = KIND_RX_OVERSIZE;
        res_next.delivered_count = cnt;
      end else begin
        res_next.kind            = KIND_DELIVERED;
        res_next.delivered_count = cnt + COUNT_W'(1);
      end
    end else if (cmd.walk_stop) begin
      emit                     = 1'b1;
      res_next.kind            = KIND_POLL_DONE;
      res_next.slot_used       = SLOT_W'(wpos);
      res_next.delivered_count = cnt;
    end
  end

  // Control and ring status registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= MAX_FRAME_LEN_RST;
      burst_limit   <= BURST_LIMIT_RST;
      up_filled     <= '0;
      down_filled   <= '0;
      up_pos        <= '0;
      down_pos      <= '0;
      link_valid    <= 1'b0;
      reset_pending <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MAX_FRAME_LEN: max_frame_len <= cfg_data;
          CFG_BURST_LIMIT:   burst_limit   <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.exec_single) begin
        unique case (cur.op)
          OP_SEND: begin
            if (send_ok) begin
              up_filled[up_pos] <= 1'b1;
              up_pos <= (up_pos == LAST_IDX) ? '0 : up_pos + IDX_W'(1);
            end
          end
          OP_FILL:  if (cur_in_range) down_filled[cur_idx] <= 1'b1;
          OP_FREE:  if (cur_in_range) up_filled[cur_idx] <= 1'b0;
          OP_RESET: reset_pending <= 1'b1;
          default: ;
        endcase
      end
      if (cmd.poll_reset) begin
        up_filled     <= '0;
        down_filled   <= '0;
        up_pos        <= '0;
        down_pos      <= '0;
        reset_pending <= 1'b0;
        link_valid    <= 1'b1;
      end
      if (cmd.walk_step) down_filled[wpos] <= 1'b0;
      if (cmd.walk_stop) down_pos <= wpos;
      if (emit)              result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

  // Slot lengths: written by guest fill only, read one slot ahead of the walker
  always_ff @(posedge clk) begin
    if (cmd.exec_single && (cur.op == OP_FILL) && cur_in_range) begin
      len_mem[cur_idx] <= cur.frame_length;
    end
    if (cmd.walk_init)      wlen <= len_mem[down_pos];
    else if (cmd.walk_step) wlen <= len_mem[wpos_inc];
  end

  // Payload registers: input word, walker, result
  always_ff @(posedge clk) begin
    if (cmd.latch_item) cur <= item;
    if (cmd.walk_init) begin
      wpos   <= down_pos;
      walked <= '0;
      cnt    <= '0;
    end else if (cmd.walk_step) begin
      wpos   <= wpos_inc;
      walked <= walked + WALK_W'(1);
      if (!wlen_over) cnt <= cnt + COUNT_W'(1);
    end
    if (emit) result <= res_next;
  end

endmodule

>>> hw/rtl/srse_chk.sv
// Port-level checks for the shared ring slot engine, bound to the top level.
module srse_chk (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input srse_pkg::result_t result
);
  import srse_pkg::*;

  // A held result stays put until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // One word in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("second word accepted back to back");

  // Only walk visits are non-final
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.last ==
                      !((result.kind == KIND_DELIVERED) || (result.kind == KIND_RX_OVERSIZE))))
    else $error("last flag does not match result kind");

  // Kind and count stay in range
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.kind <= KIND_RESET_DONE) &&
                     (result.delivered_count <= COUNT_W'(32)))
    else $error("result kind or count out of range");

endmodule

bind shared_ring_slot_engine srse_chk u_srse_chk (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
